### design/psd_pkg.sv
// ============================================================================
// Population standard deviation engine - shared definitions
// Sizes, operation codes and the control structs that pass between the
// sequencer and the shared shift-subtract unit.
// ============================================================================
package psd_pkg;

	// Capacity of the sample store and the widths that follow from it.
	localparam int MAX_SAMPLES = 1024;
	localparam int ADDR_W      = $clog2(MAX_SAMPLES);
	localparam int CNT_W       = 11;

	// Field widths of one beat.
	localparam int SAMPLE_W    = 16;
	localparam int STD_W       = 24;

	// Running sum, mean and deviation widths.
	localparam int SUM_W       = 27;
	localparam int MEAN_W      = 17;
	localparam int DEV_W       = 18;
	localparam int SQ_W        = 32;
	localparam int DEV_SUM_W   = 43;
	localparam int FRAC_W      = 16;

	// Shared shift-subtract unit.
	localparam int ACC_W       = 60;
	localparam int REM_W       = 33;
	localparam int ROOT_W      = 30;
	localparam int STEP_W      = 6;
	localparam int DIV_STEPS   = 60;
	localparam int SQRT_STEPS  = 30;

	// Operation codes of the shared unit.
	localparam logic OP_DIV    = 1'b0;
	localparam logic OP_SQRT   = 1'b1;

	// Command from the sequencer to the shared unit.
	typedef struct packed {
		logic go;
		logic op;
	} unit_cmd_t;

	// Status from the shared unit back to the sequencer.
	typedef struct packed {
		logic             done;
		logic [ACC_W-1:0] result;
	} unit_stat_t;

endpackage

### design/psd_ram.sv
// ============================================================================
// Generic RAM
// One write port and one read port, with the read data registered.
// ============================================================================
module psd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### design/psd_unit.sv
// ============================================================================
// Shared shift-subtract unit
// Restoring division by an 11-bit count (one quotient bit a cycle) and
// integer square root (one root bit a cycle) on one compare-subtract path.
// ============================================================================
module psd_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  psd_pkg::unit_cmd_t           cmd,
	input  logic [psd_pkg::ACC_W-1:0]    operand,
	input  logic [psd_pkg::CNT_W-1:0]    divisor,
	output psd_pkg::unit_stat_t          stat
);

	logic [psd_pkg::ACC_W-1:0]  acc_q;
	logic [psd_pkg::REM_W-1:0]  rem_q;
	logic [psd_pkg::ROOT_W-1:0] root_q;
	logic [psd_pkg::STEP_W-1:0] step_q;
	logic                       run_q;
	logic                       op_q;
	logic                       done_q;

	logic [psd_pkg::REM_W-1:0]  shifted;
	logic [psd_pkg::REM_W-1:0]  trial;
	logic [psd_pkg::REM_W:0]    diff;
	logic                       fits;
	logic [psd_pkg::STEP_W-1:0] last_step;

	// Bring in the next digit and try the subtraction.
	always_comb begin
		if (op_q == psd_pkg::OP_SQRT) begin
			shifted   = {rem_q[psd_pkg::REM_W-3:0], acc_q[psd_pkg::ACC_W-1 -: 2]};
			trial     = {1'b0, root_q, 2'b01};
			last_step = psd_pkg::STEP_W'(psd_pkg::SQRT_STEPS - 1);
		end else begin
			shifted   = {rem_q[psd_pkg::REM_W-2:0], acc_q[psd_pkg::ACC_W-1]};
			trial     = psd_pkg::REM_W'(divisor);
			last_step = psd_pkg::STEP_W'(psd_pkg::DIV_STEPS - 1);
		end
		diff = {1'b0, shifted} - {1'b0, trial};
		fits = ~diff[psd_pkg::REM_W];
	end

	// Iteration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
			op_q   <= psd_pkg::OP_DIV;
		end else begin
			done_q <= 1'b0;
			if (cmd.go) begin
				run_q  <= 1'b1;
				step_q <= '0;
				op_q   <= cmd.op;
			end else if (run_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == last_step) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: the remainder, the shifting operand and the root.
	always_ff @(posedge clk) begin
		if (cmd.go) begin
			acc_q  <= operand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (run_q) begin
			if (fits) begin
				rem_q <= diff[psd_pkg::REM_W-1:0];
			end else begin
				rem_q <= shifted;
			end
			if (op_q == psd_pkg::OP_SQRT) begin
				acc_q  <= {acc_q[psd_pkg::ACC_W-3:0], 2'b00};
				root_q <= {root_q[psd_pkg::ROOT_W-2:0], fits};
			end else begin
				acc_q  <= {acc_q[psd_pkg::ACC_W-2:0], fits};
			end
		end
	end

	// The quotient replaces the dividend; the root has its own register.
	always_comb begin
		stat.done = done_q;
		if (op_q == psd_pkg::OP_SQRT) begin
			stat.result = psd_pkg::ACC_W'(root_q);
		end else begin
			stat.result = acc_q;
		end
	end

endmodule

### design/population_std_dev_engine_top.sv
// ============================================================================
// Population standard deviation engine
// Collects signed samples and returns the population standard deviation of
// each set with 8 fraction bits, by a two-pass mean and deviation sum.
// ============================================================================
// Usage:
// An input beat (sample_value, present, last_item) is taken at a rising edge
// where start is high and busy is low. A beat with present set is written
// into the sample store and added to the count and the sum; once the store
// holds 1024 samples, further present samples are dropped and noted.
// A beat without last_item leaves busy low, so samples
// can load on every cycle.
// A beat with last_item closes the set. With an empty set the result comes
// on the next cycle. Otherwise busy rises and the block runs the mean
// division, a pass over the n stored samples, the variance division and
// the square root, all on one shared shift-subtract unit, and then shows
// the result.
// The result beat (std_dev, sample_count, overflowed) is shown for one cycle
// with done high; the receiver cannot hold it off. busy is low in that cycle
// and the count and sum are already cleared for the next set.
// Reset empties the set; the store contents need no clearing.
// ============================================================================
module population_std_dev_engine_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [psd_pkg::SAMPLE_W-1:0] sample_value,
	input  logic                                present,
	input  logic                                last_item,
	output logic                                done,
	output logic [psd_pkg::STD_W-1:0]           std_dev,
	output logic [psd_pkg::CNT_W-1:0]           sample_count,
	output logic                                overflowed
);

	// Sequencer state codes.
	localparam logic [2:0] S_LOAD      = 3'd0;
	localparam logic [2:0] S_MEAN_GO   = 3'd1;
	localparam logic [2:0] S_MEAN_WAIT = 3'd2;
	localparam logic [2:0] S_PASS      = 3'd3;
	localparam logic [2:0] S_VAR_GO    = 3'd4;
	localparam logic [2:0] S_VAR_WAIT  = 3'd5;
	localparam logic [2:0] S_ROOT_GO   = 3'd6;
	localparam logic [2:0] S_ROOT_WAIT = 3'd7;

	logic [2:0]                            state_q;
	logic [psd_pkg::CNT_W-1:0]             count_q;
	logic signed [psd_pkg::SUM_W-1:0]      sum_q;
	logic                                  drop_q;
	logic signed [psd_pkg::MEAN_W-1:0]     mean_q;
	logic [psd_pkg::CNT_W-1:0]             iss_q;
	logic                                  v_s1;
	logic                                  v_s2;
	logic [psd_pkg::SQ_W-1:0]              sq_s2;
	logic [psd_pkg::DEV_SUM_W-1:0]         dev_sum_q;
	logic                                  done_q;
	logic [psd_pkg::STD_W-1:0]             std_dev_q;
	logic [psd_pkg::CNT_W-1:0]             sample_count_q;
	logic                                  overflowed_q;

	logic                                  accept;
	logic                                  room;
	logic                                  take;
	logic [psd_pkg::CNT_W-1:0]             cnt_next;
	logic                                  rd_en;
	logic signed [psd_pkg::SAMPLE_W-1:0]   rd_data;
	logic [psd_pkg::SUM_W-1:0]             sum_abs;
	logic [psd_pkg::MEAN_W-1:0]            quot;
	logic signed [psd_pkg::DEV_W-1:0]      dev;
	logic [psd_pkg::DEV_W-1:0]             dev_abs;
	logic [2*psd_pkg::MEAN_W-1:0]          square;
	psd_pkg::unit_cmd_t                    cmd;
	psd_pkg::unit_stat_t                   stat;
	logic [psd_pkg::ACC_W-1:0]             operand;

	// Input beat handshake and store admission.
	assign busy     = (state_q != S_LOAD);
	assign accept   = start && !busy;
	assign room     = (count_q < psd_pkg::CNT_W'(psd_pkg::MAX_SAMPLES));
	assign take     = accept && present && room;
	assign cnt_next = count_q + psd_pkg::CNT_W'(take);
	assign rd_en    = (state_q == S_PASS) && (iss_q != count_q);

	// Sample store.
	psd_ram #(
		.WIDTH(psd_pkg::SAMPLE_W),
		.DEPTH(psd_pkg::MAX_SAMPLES)
	) u_store (
		.clk  (clk),
		.we   (take),
		.waddr(count_q[psd_pkg::ADDR_W-1:0]),
		.wdata(sample_value),
		.raddr(iss_q[psd_pkg::ADDR_W-1:0]),
		.rdata(rd_data)
	);

	// Magnitude of the sum, the unsigned quotient and the deviation of one sample.
	always_comb begin
		sum_abs = sum_q[psd_pkg::SUM_W-1] ? psd_pkg::SUM_W'(-sum_q) : psd_pkg::SUM_W'(sum_q);
		quot    = stat.result[psd_pkg::MEAN_W-1:0];
		dev     = psd_pkg::DEV_W'(mean_q) - psd_pkg::DEV_W'(rd_data);
		dev_abs = dev[psd_pkg::DEV_W-1] ? psd_pkg::DEV_W'(-dev) : psd_pkg::DEV_W'(dev);
		square  = dev_abs[psd_pkg::MEAN_W-1:0] * dev_abs[psd_pkg::MEAN_W-1:0];
	end

	// Commands to the shared unit.
	always_comb begin
		cmd.go = (state_q == S_MEAN_GO) || (state_q == S_VAR_GO) || (state_q == S_ROOT_GO);
		cmd.op = (state_q == S_ROOT_GO) ? psd_pkg::OP_SQRT : psd_pkg::OP_DIV;
		unique case (state_q)
			S_MEAN_GO: begin
				operand = psd_pkg::ACC_W'(sum_abs);
			end
			S_VAR_GO: begin
				operand = psd_pkg::ACC_W'({dev_sum_q, psd_pkg::FRAC_W'(0)});
			end
			default: begin
				operand = stat.result;
			end
		endcase
	end

	psd_unit u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.operand(operand),
		.divisor(count_q),
		.stat   (stat)
	);

	// Sequencer, set bookkeeping and the result beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			count_q <= '0;
			sum_q   <= '0;
			drop_q  <= 1'b0;
			iss_q   <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			v_s1   <= rd_en;
			v_s2   <= v_s1;
			unique case (state_q)
				S_LOAD: begin
					if (accept) begin
						if (take) begin
							count_q <= cnt_next;
							sum_q   <= sum_q + psd_pkg::SUM_W'(sample_value);
						end
						if (present && !room) begin
							drop_q <= 1'b1;
						end
						if (last_item) begin
							if (cnt_next == '0) begin
								done_q <= 1'b1;
								drop_q <= 1'b0;
							end else begin
								state_q <= S_MEAN_GO;
							end
						end
					end
				end
				S_MEAN_GO: begin
					state_q <= S_MEAN_WAIT;
				end
				S_MEAN_WAIT: begin
					if (stat.done) begin
						iss_q   <= '0;
						state_q <= S_PASS;
					end
				end
				S_PASS: begin
					if (rd_en) begin
						iss_q <= iss_q + 1'b1;
					end else if (!v_s1 && !v_s2) begin
						state_q <= S_VAR_GO;
					end
				end
				S_VAR_GO: begin
					state_q <= S_VAR_WAIT;
				end
				S_VAR_WAIT: begin
					if (stat.done) begin
						state_q <= S_ROOT_GO;
					end
				end
				S_ROOT_GO: begin
					state_q <= S_ROOT_WAIT;
				end
				S_ROOT_WAIT: begin
					if (stat.done) begin
						done_q  <= 1'b1;
						count_q <= '0;
						sum_q   <= '0;
						drop_q  <= 1'b0;
						state_q <= S_LOAD;
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	// Mean and deviation pass datapath.
	always_ff @(posedge clk) begin
		if (state_q == S_MEAN_WAIT && stat.done) begin
			mean_q    <= sum_q[psd_pkg::SUM_W-1] ? psd_pkg::MEAN_W'(-quot) : quot;
			dev_sum_q <= '0;
		end else if (v_s2) begin
			dev_sum_q <= dev_sum_q + psd_pkg::DEV_SUM_W'(sq_s2);
		end
		sq_s2 <= square[psd_pkg::SQ_W-1:0];
	end

	// Result beat payload.
	always_ff @(posedge clk) begin
		if (state_q == S_LOAD) begin
			std_dev_q      <= '0;
			sample_count_q <= cnt_next;
			overflowed_q   <= drop_q || (accept && present && !room);
		end else if (state_q == S_ROOT_WAIT && stat.done) begin
			std_dev_q      <= stat.result[psd_pkg::STD_W-1:0];
			sample_count_q <= count_q;
			overflowed_q   <= drop_q;
		end
	end

	assign done         = done_q;
	assign std_dev      = std_dev_q;
	assign sample_count = sample_count_q;
	assign overflowed   = overflowed_q;

endmodule

### design/psd_checker.sv
// ============================================================================
// Population standard deviation engine - port checker
// Watches the top-level ports over time and flags results that break the
// block's rules on sets, counts and handshakes.
// ============================================================================
module psd_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                start,
	input logic                                busy,
	input logic signed [psd_pkg::SAMPLE_W-1:0] sample_value,
	input logic                                present,
	input logic                                last_item,
	input logic                                done,
	input logic [psd_pkg::STD_W-1:0]           std_dev,
	input logic [psd_pkg::CNT_W-1:0]           sample_count,
	input logic                                overflowed
);

	// A closing beat either starts the computation or yields the result at once.
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && last_item) |=> (busy || done))
		else $error("closing beat neither started work nor gave a result");

	// A result beat is never shown while the engine is still working.
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat shown while busy");

	// Samples are dropped only once the store is full.
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && overflowed) |-> (sample_count == psd_pkg::CNT_W'(psd_pkg::MAX_SAMPLES)))
		else $error("overflow reported with the store not full");

	// An empty set has zero deviation.
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && sample_count == '0) |-> (std_dev == '0))
		else $error("empty set gave a nonzero deviation");

endmodule

bind population_std_dev_engine_top psd_checker u_psd_checker (.*);
